/* src/vocontact_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vocontact_pkg
// shared constants for the velocity obstacle contact time block
// ----------------------------------------------------------------------------
package vocontact_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int TIME_FRAC_BITS = 10;
  localparam int HORIZON_W      = 16;
  localparam logic [HORIZON_W-1:0] HORIZON_RESET = 16'd3072;
  // flags carried beside the datapath: start inside, closing, root candidate
  localparam int FLAG_W = 3;
endpackage

/* src/vocontact_sqrt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vocontact_sqrt_cell
// one digit step of a pipelined truncating square root, one root bit per cell
// ----------------------------------------------------------------------------
module vocontact_sqrt_cell #(
  parameter int SW     = 33,
  parameter int DW     = 66,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SW+1:0]     in_rem,
  input  logic [SW-1:0]     in_root,
  input  logic [DW-1:0]     in_d,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [SW+1:0]     out_rem,
  output logic [SW-1:0]     out_root,
  output logic [DW-1:0]     out_d,
  output logic [SIDE_W-1:0] out_side
);
  logic              valid_r;
  logic [SW+1:0]     rem_r, rem_nxt, rem_sh, trial;
  logic [SW-1:0]     root_r, root_nxt;
  logic [DW-1:0]     d_r;
  logic [SIDE_W-1:0] side_r;

  always_comb begin
    rem_sh = {in_rem[SW-1:0], in_d[DW-1:DW-2]};
    trial  = {in_root, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {in_root[SW-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {in_root[SW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      d_r    <= {in_d[DW-3:0], 2'b00};
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_d     = d_r;
  assign out_side  = side_r;
endmodule

/* src/vocontact_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vocontact_div_cell
// one restoring division step, one quotient bit per cell
// ----------------------------------------------------------------------------
module vocontact_div_cell #(
  parameter int QW     = 43,
  parameter int DENW   = 33,
  parameter int SIDE_W = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DENW:0]     in_rem,
  input  logic [QW-1:0]     in_num,
  input  logic [QW-1:0]     in_q,
  input  logic [DENW-1:0]   in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [DENW:0]     out_rem,
  output logic [QW-1:0]     out_num,
  output logic [QW-1:0]     out_q,
  output logic [DENW-1:0]   out_den,
  output logic [SIDE_W-1:0] out_side
);
  logic              valid_r;
  logic [DENW:0]     rem_r, rem_nxt, rem_sh;
  logic [QW-1:0]     num_r, q_r;
  logic [DENW-1:0]   den_r;
  logic [SIDE_W-1:0] side_r;
  logic              ge;

  always_comb begin
    rem_sh  = {in_rem[DENW-1:0], in_num[QW-1]};
    ge      = rem_sh >= {1'b0, in_den};
    rem_nxt = ge ? (rem_sh - {1'b0, in_den}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      num_r  <= {in_num[QW-2:0], 1'b0};
      q_r    <= {in_q[QW-2:0], ge};
      den_r  <= in_den;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_num   = num_r;
  assign out_q     = q_r;
  assign out_den   = den_r;
  assign out_side  = side_r;
endmodule

/* src/velocity_obstacle_contact_time_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_obstacle_contact_time_top
// first contact time of two discs in relative motion, fully pipelined
// ----------------------------------------------------------------------------
// One request enters per clock and one result leaves per clock. The pipeline
// runs through the stages of products, sums and compares, then a chain of
// square root cells with one root bit each, a chain of restoring division
// cells with one quotient bit each, and the output register. The whole
// pipeline holds while a result waits on out_tready. horizon is sampled at
// the output stage.
module velocity_obstacle_contact_time_top #(
  parameter int COORD_BITS = vocontact_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_wr_en,
  input  logic [vocontact_pkg::HORIZON_W-1:0] cfg_wr_data,
  input  logic in_tvalid,
  output logic in_tready,
  // rel_pos_x, rel_pos_y, rel_vel_x, rel_vel_y, contact_radius
  input  logic [((5*COORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // contact_time
  output logic [vocontact_pkg::HORIZON_W-1:0] out_tdata,
  // contact
  output logic out_tuser
);
  localparam int CB   = COORD_BITS;
  localparam int P2W  = 2*CB+1;
  localparam int DW   = 2*P2W;
  localparam int SW   = P2W;
  localparam int TF   = vocontact_pkg::TIME_FRAC_BITS;
  localparam int QW   = P2W+TF;
  localparam int FW   = vocontact_pkg::FLAG_W;
  localparam int SQSW = FW+2*P2W;
  localparam int HW   = vocontact_pkg::HORIZON_W;

  logic en;
  logic [HW-1:0] horizon_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      horizon_r <= vocontact_pkg::HORIZON_RESET;
    end else if (cfg_wr_en) begin
      horizon_r <= cfg_wr_data;
    end
  end

  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // stage 1: products
  logic signed [CB-1:0] px, py, wx, wy;
  logic [CB-1:0] rr;
  assign px = in_tdata[CB-1:0];
  assign py = in_tdata[2*CB-1:CB];
  assign wx = in_tdata[3*CB-1:2*CB];
  assign wy = in_tdata[4*CB-1:3*CB];
  assign rr = in_tdata[5*CB-1:4*CB];

  logic v1_r;
  logic signed [2*CB-1:0] pxx_r, pyy_r, pxwx_r, pywy_r, wxx_r, wyy_r;
  logic [2*CB-1:0] rr2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxx_r  <= px * px;
      pyy_r  <= py * py;
      pxwx_r <= px * wx;
      pywy_r <= py * wy;
      wxx_r  <= wx * wx;
      wyy_r  <= wy * wy;
      rr2_r  <= rr * rr;
    end
  end

  // stage 2: sums
  logic v2_r;
  logic [P2W-1:0] pn2_r, wn2_r, r2_r;
  logic signed [P2W-1:0] c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pn2_r <= {1'b0, pxx_r} + {1'b0, pyy_r};
      wn2_r <= {1'b0, wxx_r} + {1'b0, wyy_r};
      r2_r  <= {1'b0, rr2_r};
      c_r   <= {pxwx_r[2*CB-1], pxwx_r} + {pywy_r[2*CB-1], pywy_r};
    end
  end

  // stage 3: inside test and distance margin
  logic v3_r, inside3_r, cpos3_r, wnz3_r;
  logic [P2W-1:0] diff3_r, wn2_3_r, c3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inside3_r <= pn2_r < r2_r;
      cpos3_r   <= (c_r > 0);
      wnz3_r    <= wn2_r != '0;
      diff3_r   <= pn2_r - r2_r;
      wn2_3_r   <= wn2_r;
      c3_r      <= c_r;
    end
  end

  // stage 4: the two wide products
  logic v4_r, inside4_r, cpos4_r, wnz4_r;
  logic [DW-1:0] c2_r, prod_r;
  logic [P2W-1:0] wn2_4_r, c4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_r      <= c3_r * c3_r;
      prod_r    <= wn2_3_r * diff3_r;
      inside4_r <= inside3_r;
      cpos4_r   <= cpos3_r;
      wnz4_r    <= wnz3_r;
      wn2_4_r   <= wn2_3_r;
      c4_r      <= c3_r;
    end
  end

  // stage 5: discriminant
  logic v5_r;
  logic [DW-1:0] disc_r;
  logic [SQSW-1:0] side5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      disc_r  <= c2_r - prod_r;
      side5_r <= {inside4_r, cpos4_r,
                  (!inside4_r && wnz4_r && cpos4_r && (c2_r > prod_r)),
                  c4_r, wn2_4_r};
    end
  end

  // square root chain
  logic            sq_v    [0:SW];
  logic [SW+1:0]   sq_rem  [0:SW];
  logic [SW-1:0]   sq_root [0:SW];
  logic [DW-1:0]   sq_d    [0:SW];
  logic [SQSW-1:0] sq_side [0:SW];

  assign sq_v[0]    = v5_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_d[0]    = disc_r;
  assign sq_side[0] = side5_r;

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    vocontact_sqrt_cell #(.SW(SW), .DW(DW), .SIDE_W(SQSW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(sq_v[i]), .in_rem(sq_rem[i]), .in_root(sq_root[i]),
      .in_d(sq_d[i]), .in_side(sq_side[i]),
      .out_valid(sq_v[i+1]), .out_rem(sq_rem[i+1]), .out_root(sq_root[i+1]),
      .out_d(sq_d[i+1]), .out_side(sq_side[i+1])
    );
  end

  // division chain: (c - s) * 2^TF / wn2
  logic [P2W-1:0] sq_c, sq_wn2;
  logic [FW-1:0]  sq_flags;
  assign sq_c     = sq_side[SW][2*P2W-1:P2W];
  assign sq_wn2   = sq_side[SW][P2W-1:0];
  assign sq_flags = sq_side[SW][SQSW-1:2*P2W];

  logic            dv_v    [0:QW];
  logic [P2W:0]    dv_rem  [0:QW];
  logic [QW-1:0]   dv_num  [0:QW];
  logic [QW-1:0]   dv_q    [0:QW];
  logic [P2W-1:0]  dv_den  [0:QW];
  logic [FW-1:0]   dv_side [0:QW];

  assign dv_v[0]    = sq_v[SW];
  assign dv_rem[0]  = '0;
  assign dv_num[0]  = {sq_c - sq_root[SW], {TF{1'b0}}};
  assign dv_q[0]    = '0;
  assign dv_den[0]  = sq_wn2;
  assign dv_side[0] = sq_flags;

  for (genvar j = 0; j < QW; j++) begin : g_div
    vocontact_div_cell #(.QW(QW), .DENW(P2W), .SIDE_W(FW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(dv_v[j]), .in_rem(dv_rem[j]), .in_num(dv_num[j]),
      .in_q(dv_q[j]), .in_den(dv_den[j]), .in_side(dv_side[j]),
      .out_valid(dv_v[j+1]), .out_rem(dv_rem[j+1]), .out_num(dv_num[j+1]),
      .out_q(dv_q[j+1]), .out_den(dv_den[j+1]), .out_side(dv_side[j+1])
    );
  end

  // output stage
  logic inside_f, cpos_f, cand_f, hit;
  logic [HW-1:0] time_nxt;
  logic contact_r;
  logic [HW-1:0] time_r;

  assign inside_f = dv_side[QW][2];
  assign cpos_f   = dv_side[QW][1];
  assign cand_f   = dv_side[QW][0];

  always_comb begin
    time_nxt = '0;
    if (inside_f) begin
      hit = cpos_f;
    end else begin
      hit = cand_f && (dv_q[QW] <= {{(QW-HW){1'b0}}, horizon_r});
      if (hit) begin
        time_nxt = dv_q[QW][HW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      contact_r <= hit;
      time_r    <= time_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = time_r;
  assign out_tuser  = contact_r;
endmodule
